// ----- rtl/pkrt_pkg.sv -----
// Shared types and codes for the position keeping risk table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pkrt_pkg;

  localparam logic [1:0] CMD_RISK  = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic CFG_MAX_POSITION    = 1'b0;
  localparam logic CFG_MAX_ORDER_VALUE = 1'b1;

  localparam logic [63:0] PNL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PNL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [39:0] QTY_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] QTY_MIN = 40'h80_0000_0000;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic        side;
    logic [31:0] price;
    logic [23:0] amount;
  } in_t;

  typedef struct packed {
    logic               risk_pass;
    logic               has_update;
    logic signed [39:0] position_qty;
    logic signed [63:0] open_pl;
    logic signed [63:0] closed_pl;
  } out_t;

  typedef struct packed {
    logic [39:0] qty;
    logic [31:0] avg;
    logic [31:0] mark;
    logic [63:0] rpnl;
    logic [63:0] upnl;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_A_LO,
    ST_A_HI,
    ST_A_SUM,
    ST_A_NUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SELL,
    ST_SELL_ACC,
    ST_P_LO,
    ST_P_HI,
    ST_P_SUM,
    ST_P_SAT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/pkrt_mem.sv -----
// Position table storage: entry data memory and entry valid memory.
// Depends on pkrt_pkg (entry_t).
`timescale 1ns / 1ps

module pkrt_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic             data_we,
  input  pkrt_pkg::entry_t wr_entry,
  input  logic             vld_we,
  input  logic             wr_vld,
  output pkrt_pkg::entry_t rd_entry,
  output logic             rd_vld
);
  import pkrt_pkg::*;

  entry_t data_mem [DEPTH];
  logic   vld_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[wr_addr] <= wr_vld;
    end
    if (rd_en) begin
      rd_vld <= vld_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/pkrt_mul.sv -----
// Shared 32x24 multiplier with registered product.
// Depends on pkrt_pkg only by convention; no types used.
`timescale 1ns / 1ps

module pkrt_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [23:0] b,
  output logic [55:0] p
);
  import pkrt_pkg::*;

  always_ff @(posedge clk) begin
    p <= 56'(a) * 56'(b);
  end

endmodule

// ----- rtl/pkrt_div.sv -----
// Radix-4 restoring divider for the average entry price; quotients of 2^32 or more are flagged by big.
// Depends on pkrt_pkg by import only.
`timescale 1ns / 1ps

module pkrt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [72:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic        big,
  output logic [31:0] quo
);
  import pkrt_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'd15;

  logic        busy;
  logic [3:0]  cnt;
  logic [39:0] rem;
  logic [31:0] dvd;
  logic [39:0] den_r;
  logic [40:0] t1, t2, hi;
  logic        ge1, ge2;
  logic [39:0] r1, r2;

  always_comb begin
    hi  = num[72:32];
    t1  = {rem, dvd[31]};
    ge1 = t1 >= {1'b0, den_r};
    r1  = ge1 ? 40'(t1 - {1'b0, den_r}) : t1[39:0];
    t2  = {r1, dvd[30]};
    ge2 = t2 >= {1'b0, den_r};
    r2  = ge2 ? 40'(t2 - {1'b0, den_r}) : t2[39:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        dvd   <= num[31:0];
        rem   <= hi[39:0];
        cnt   <= '0;
        // quotient of 2^32 or more: flagged as big and done right away
        if (hi >= {1'b0, den}) begin
          big  <= 1'b1;
          done <= 1'b1;
        end else begin
          big  <= 1'b0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= r2;
        dvd <= {dvd[29:0], ge1, ge2};
        cnt <= cnt + 4'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = dvd;

endmodule

// ----- rtl/position_keeping_risk_table_top.sv -----
// Top level of the position keeping risk table: sequencer and datapath.
// Depends on pkrt_pkg, pkrt_mem, pkrt_mul and pkrt_div.
`timescale 1ns / 1ps

// Per-symbol position table with risk check, fill booking and mark-to-market.
// Input channel in_valid/in_ready/in_data carries one command beat; output
// channel out_valid/out_ready/out_data returns exactly one result beat per
// command. Limits are written over cfg_we/cfg_index/cfg_data while idle.
// One command is worked at a time, through a read-modify-write of one entry.
// Each command is read and decoded; a risk check, unused code and tick of a
// missing entry then go straight to the result, a tick and sell fill through
// the mark-to-market product, a buy fill first through the 2-bit-per-cycle
// divider for the average price (ended at once if the quotient caps, skipped
// if the buy flattens). The next beat is taken the cycle after results load.
// A 32x24 multiplier is shared; wide products take two passes through it.
// After reset the valid memory is swept clear, one entry a cycle, with in_ready
// low throughout the sweep; config writes are taken during the sweep.
// The result waits in the output register while the receiver stalls; the
// next command is taken meanwhile and its result holds until the slot frees.
module position_keeping_risk_table_top #(
  parameter int SYMBOLS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pkrt_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pkrt_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [55:0]     cfg_data
);
  import pkrt_pkg::*;

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(SYMBOLS - 1);
  // floor reciprocal for symbol modulo SYMBOLS when the table is small
  localparam logic [16:0] RECIP = 17'(65536 / SYMBOLS);
  localparam logic [8:0]  SYM9  = 9'(SYMBOLS);

  state_t state, state_next;

  logic [38:0] max_position;
  logic [55:0] order_limit;

  in_t         item;
  logic [AW-1:0] idx, idx_next, clr_cnt;
  logic        upd_r, pass_r;
  logic [39:0] q_w, nq;
  logic [31:0] avg_w;
  logic [63:0] real_w, unreal_w;
  logic [55:0] vm;
  logic [51:0] acc;
  logic [71:0] prod_r;
  logic [72:0] num;
  logic        nneg;

  // memory and unit hookups
  logic        rd_en, data_we, vld_we, wr_vld;
  logic [AW-1:0] wr_addr;
  entry_t      rd_entry, wr_entry;
  logic        rd_vld;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic        div_start, div_done, div_big;
  logic [31:0] div_quo;
  logic        load_out;

  // decode-time values
  logic [39:0] q_in;
  logic [40:0] s41, mag41;
  logic [39:0] clamp_q;
  logic [39:0] qmag, nqmag;
  logic [31:0] dmag;
  logic        dneg;
  logic [24:0] mod_prod;
  logic [7:0]  mod_q;
  logic [8:0]  mod_r;
  logic [72:0] num_c;
  logic        nneg_c;
  logic [64:0] r65;
  logic [63:0] pnl_c;
  logic [31:0] avg_div;

  pkrt_mem #(.DEPTH(SYMBOLS), .AW(AW)) u_mem (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (idx),
    .wr_addr  (wr_addr),
    .data_we  (data_we),
    .wr_entry (wr_entry),
    .vld_we   (vld_we),
    .wr_vld   (wr_vld),
    .rd_entry (rd_entry),
    .rd_vld   (rd_vld)
  );

  pkrt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pkrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (nqmag),
    .done  (div_done),
    .big   (div_big),
    .quo   (div_quo)
  );

  // symbol index modulo the table depth
  always_comb begin
    mod_prod = 25'(in_data.symbol) * 25'(RECIP);
    mod_q    = mod_prod[23:16];
    mod_r    = {1'b0, in_data.symbol} - 9'(mod_q * SYM9);
    if (mod_r >= SYM9) begin
      mod_r = mod_r - SYM9;
    end
    if (SYMBOLS >= 256) begin
      idx_next = AW'(in_data.symbol);
    end else begin
      idx_next = AW'(mod_r);
    end
  end

  // datapath helpers
  always_comb begin
    q_in    = rd_vld ? rd_entry.qty : '0;
    s41     = item.side ? ({q_in[39], q_in} - {17'd0, item.amount})
                        : ({q_in[39], q_in} + {17'd0, item.amount});
    mag41   = s41[40] ? 41'(-s41) : s41;
    if (!s41[40] && s41[39]) begin
      clamp_q = QTY_MAX;
    end else if (s41[40] && !s41[39]) begin
      clamp_q = QTY_MIN;
    end else begin
      clamp_q = s41[39:0];
    end
    qmag  = q_w[39] ? 40'(-q_w) : q_w;
    nqmag = nq[39] ? 40'(-nq) : nq;
    dneg  = item.price < avg_w;
    dmag  = dneg ? (avg_w - item.price) : (item.price - avg_w);

    // signed numerator of the new average
    if (!q_w[39]) begin
      num_c  = 73'(prod_r) + 73'(vm);
      nneg_c = 1'b0;
    end else if (prod_r > 72'(vm)) begin
      num_c  = 73'(prod_r - 72'(vm));
      nneg_c = 1'b1;
    end else begin
      num_c  = 73'(72'(vm) - prod_r);
      nneg_c = 1'b0;
    end

    avg_div = (nneg != nq[39]) ? 32'd0 : (div_big ? 32'hFFFF_FFFF : div_quo);

    // realized accumulation, saturating
    r65 = dneg ? ({real_w[63], real_w} - {9'd0, mul_p})
               : ({real_w[63], real_w} + {9'd0, mul_p});

    // unrealized product, saturating
    if (!(dneg ^ nq[39])) begin
      pnl_c = (|prod_r[71:63]) ? PNL_MAX : prod_r[63:0];
    end else begin
      pnl_c = (|prod_r[71:63]) ? PNL_MIN : 64'(-prod_r[63:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_READ;
      ST_READ:     state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (item.command)
          CMD_FILL: state_next = item.side ? ST_SELL : ST_A_LO;
          CMD_TICK: state_next = rd_vld ? ST_P_LO : ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_A_LO:     state_next = ST_A_HI;
      ST_A_HI:     state_next = ST_A_SUM;
      ST_A_SUM:    state_next = ST_A_NUM;
      ST_A_NUM:    state_next = (nq == '0) ? ST_P_LO : ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_P_LO;
      ST_SELL:     state_next = ST_SELL_ACC;
      ST_SELL_ACC: state_next = ST_P_LO;
      ST_P_LO:     state_next = ST_P_HI;
      ST_P_HI:     state_next = ST_P_SUM;
      ST_P_SUM:    state_next = ST_P_SAT;
      ST_P_SAT:    state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    data_we   = 1'b0;
    vld_we    = 1'b0;
    wr_vld    = 1'b0;
    wr_addr   = idx;
    mul_a     = dmag;
    mul_b     = {4'd0, nqmag[19:0]};
    unique case (state)
      ST_CLEAR: begin
        vld_we  = 1'b1;
        wr_addr = clr_cnt;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_READ: begin
        rd_en = 1'b1;
        mul_a = item.price;
        mul_b = item.amount;
      end
      ST_A_LO: begin
        mul_a = avg_w;
        mul_b = {4'd0, qmag[19:0]};
      end
      ST_A_HI: begin
        mul_a = avg_w;
        mul_b = {4'd0, qmag[39:20]};
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_SELL:   mul_b = item.amount;
      ST_P_HI:   mul_b = {4'd0, nqmag[39:20]};
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          data_we  = upd_r;
          vld_we   = upd_r;
          wr_vld   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_entry = '{qty: nq, avg: avg_w, mark: item.price, rpnl: real_w, upnl: unreal_w};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
      max_position <= '0;
      order_limit  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_POSITION:    max_position <= cfg_data[38:0];
          CFG_MAX_ORDER_VALUE: order_limit  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state) inside
      ST_IDLE: begin
        item <= in_data;
        idx  <= idx_next;
      end
      ST_DECODE: begin
        vm       <= mul_p;
        q_w      <= q_in;
        avg_w    <= rd_vld ? rd_entry.avg  : '0;
        real_w   <= rd_vld ? rd_entry.rpnl : '0;
        unreal_w <= rd_vld ? rd_entry.upnl : '0;
        nq       <= (item.command == CMD_FILL) ? clamp_q : q_in;
        upd_r    <= (item.command == CMD_FILL) || (item.command == CMD_TICK && rd_vld);
        pass_r   <= (item.command == CMD_RISK) && (mag41 <= {2'd0, max_position})
                    && (mul_p <= order_limit);
      end
      ST_A_HI, ST_P_HI: acc <= mul_p[51:0];
      ST_A_SUM, ST_P_SUM: prod_r <= 72'(acc) + {mul_p[51:0], 20'd0};
      ST_A_NUM: begin
        num  <= num_c;
        nneg <= nneg_c;
        if (nq == '0) begin
          avg_w <= '0;
        end
      end
      ST_DIV_WAIT: if (div_done) avg_w <= avg_div;
      ST_SELL_ACC: begin
        if (r65[64] != r65[63]) begin
          real_w <= r65[64] ? PNL_MIN : PNL_MAX;
        end else begin
          real_w <= r65[63:0];
        end
        if (nq == '0) begin
          avg_w <= '0;
        end
      end
      ST_P_SAT: unreal_w <= pnl_c;
      ST_DONE: begin
        if (load_out) begin
          out_data.risk_pass    <= pass_r;
          out_data.has_update   <= upd_r;
          out_data.position_qty <= nq;
          out_data.open_pl      <= unreal_w;
          out_data.closed_pl    <= real_w;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for position_keeping_risk_table_top.
// Depends on pkrt_pkg and the block's RTL; predicts each result beat in-line.
`timescale 1ns / 1ps

module tb;
  import pkrt_pkg::*;

  localparam int SYMBOLS = 256;
  localparam longint QTY_HI = 64'sd549755813887;
  localparam longint QTY_LO = -64'sd549755813888;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MAX_POSITION;
  logic [55:0] cfg_data = '0;

  position_keeping_risk_table_top #(.SYMBOLS(SYMBOLS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow of the position table and the limit registers.
  bit          entry_ok [SYMBOLS];
  longint      pos_tab  [SYMBOLS];
  logic [31:0] avg_tab  [SYMBOLS];
  logic [31:0] mark_tab [SYMBOLS];
  longint      real_tab [SYMBOLS];
  longint      unreal_tab [SYMBOLS];
  logic [38:0] lim_pos = '0;
  logic [55:0] lim_value = '0;

  in_t  pending_cmds [$];
  out_t expected_reports [$];
  int   cmds_taken = 0;
  int   mismatches = 0;
  bit   in_took = 1'b0;

  function automatic longint clamp_qty(longint v);
    if (v > QTY_HI) return QTY_HI;
    if (v < QTY_LO) return QTY_LO;
    return v;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return PNL_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return PNL_MIN;
    return s[63:0];
  endfunction

  // (mark - average) * position, clamped to 64 bits signed
  function automatic longint mark_pnl(logic [31:0] mark, logic [31:0] avg, longint qty);
    logic signed [127:0] p;
    p = ($signed({96'd0, mark}) - $signed({96'd0, avg})) * 128'(qty);
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return PNL_MAX;
    if (p < -128'sh8000_0000_0000_0000) return PNL_MIN;
    return p[63:0];
  endfunction

  // Weighted average after a buy; truncates toward zero, clamps to price range.
  function automatic logic [31:0] buy_avg(logic [31:0] avg, longint q, logic [31:0] price,
                                          logic [23:0] amt, longint nq);
    logic signed [127:0] num, quo;
    if (nq == 0) return '0;
    num = $signed({96'd0, avg}) * 128'(q) + $signed({96'd0, price}) * $signed({104'd0, amt});
    quo = num / 128'(nq);
    if (quo <= 0) return '0;
    if (quo > 128'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return quo[31:0];
  endfunction

  // Applies one command to the shadow table and returns its report.
  function automatic out_t book_command(in_t c);
    out_t   r;
    int     s;
    longint amt, cur, np, mag, q, nq, d;
    logic [63:0] ov;
    r = '0;
    s = c.symbol;
    amt = longint'({40'd0, c.amount});
    case (c.command)
      CMD_RISK: begin
        cur = entry_ok[s] ? pos_tab[s] : 0;
        np = c.side ? cur - amt : cur + amt;
        mag = np < 0 ? -np : np;
        ov = {32'd0, c.price} * {40'd0, c.amount};
        r.risk_pass = (mag <= longint'({25'd0, lim_pos})) && (ov <= {8'd0, lim_value});
      end
      CMD_FILL: begin
        if (!entry_ok[s]) begin
          entry_ok[s] = 1'b1;
          pos_tab[s] = 0;
          avg_tab[s] = '0;
          mark_tab[s] = '0;
          real_tab[s] = 0;
          unreal_tab[s] = 0;
        end
        q = pos_tab[s];
        if (!c.side) begin
          nq = clamp_qty(q + amt);
          avg_tab[s] = buy_avg(avg_tab[s], q, c.price, c.amount, nq);
        end else begin
          d = longint'({32'd0, c.price}) - longint'({32'd0, avg_tab[s]});
          nq = clamp_qty(q - amt);
          real_tab[s] = sat_sum(real_tab[s], d * amt);
          if (nq == 0) avg_tab[s] = '0;
        end
        pos_tab[s] = nq;
        mark_tab[s] = c.price;
        unreal_tab[s] = mark_pnl(c.price, avg_tab[s], nq);
        r.has_update = 1'b1;
      end
      CMD_TICK: begin
        if (entry_ok[s]) begin
          mark_tab[s] = c.price;
          unreal_tab[s] = mark_pnl(c.price, avg_tab[s], pos_tab[s]);
          r.has_update = 1'b1;
        end
      end
      default: ;
    endcase
    if (entry_ok[s]) begin
      r.position_qty = pos_tab[s][39:0];
      r.open_pl = unreal_tab[s];
      r.closed_pl = real_tab[s];
    end
    return r;
  endfunction

  // Sender: bursts of beats separated by random gaps.
  int burst_left = 5;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: free-running stretches, random stalls, and one long hold-off
  // so results back up and the block drops in_ready.
  int  rx_phase = 0;
  int  long_hold = 0;
  bit  long_done = 1'b0;
  always @(negedge clk) begin
    rx_phase = (rx_phase + 1) % 200;
    if (!long_done && cmds_taken >= 250) begin
      long_done = 1'b1;
      long_hold = 300;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else if (rx_phase < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 55);
    end
  end

  // Monitor: predict on each accepted command beat, check each result beat.
  always @(posedge clk) begin
    out_t want;
    in_took <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(book_command(in_data));
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          want = expected_reports.pop_front();
          if (out_data.risk_pass !== want.risk_pass
              || out_data.has_update !== want.has_update
              || out_data.position_qty !== want.position_qty
              || out_data.open_pl !== want.open_pl
              || out_data.closed_pl !== want.closed_pl) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pass %0d/%0d upd %0d/%0d qty %0d/%0d upnl %0d/%0d rpnl %0d/%0d",
                       want.risk_pass, out_data.risk_pass, want.has_update, out_data.has_update,
                       want.position_qty, out_data.position_qty,
                       want.open_pl, out_data.open_pl,
                       want.closed_pl, out_data.closed_pl);
          end
        end
      end
    end
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [7:0] sym, logic sd,
                           logic [31:0] price, logic [23:0] amt);
    in_t c;
    c.command = cmd;
    c.symbol = sym;
    c.side = sd;
    c.price = price;
    c.amount = amt;
    pending_cmds.push_back(c);
  endtask

  // Limits change only with nothing in flight.
  task automatic set_limits(logic [38:0] p, logic [55:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_POSITION;
    cfg_data <= {17'd0, p};
    @(negedge clk);
    cfg_index <= CFG_MAX_ORDER_VALUE;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_pos = p;
    lim_value = v;
  endtask

  // Sender holds off until every report is back, plus the block's worst latency.
  task automatic drain;
    wait (pending_cmds.size() == 0 && !in_valid && expected_reports.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [31:0] price;
    logic [23:0] amt;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      cmd = k < 45 ? CMD_FILL : k < 75 ? CMD_RISK : k < 95 ? CMD_TICK : CMD_SPARE;
      // a small working set of symbols builds up deep positions
      sym = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
      case ($urandom_range(0, 7)) inside
        0: price = '0;
        1: price = 32'hFFFF_FFFF;
        2, 3: price = $urandom;
        default: price = $urandom_range(900, 1100);
      endcase
      case ($urandom_range(0, 7)) inside
        0: amt = '0;
        1: amt = 24'hFF_FFFF;
        2, 3: amt = 24'($urandom);
        default: amt = 24'($urandom_range(1, 2000));
      endcase
      queue_cmd(cmd, sym, 1'($urandom), price, amt);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_limits(39'd1000, 56'd1_000_000);

    // directed: limit edges, missing entries, flattening buys and sells, extremes
    queue_cmd(CMD_RISK, 8'd5, 1'b0, 32'd100, 24'd1000);
    queue_cmd(CMD_RISK, 8'd5, 1'b0, 32'd100, 24'd1001);
    queue_cmd(CMD_RISK, 8'd5, 1'b1, 32'd10001, 24'd100);
    queue_cmd(CMD_TICK, 8'd5, 1'b0, 32'd77, 24'd0);
    queue_cmd(CMD_SPARE, 8'd5, 1'b1, 32'd5, 24'd5);
    queue_cmd(CMD_FILL, 8'd5, 1'b0, 32'd100, 24'd600);
    queue_cmd(CMD_FILL, 8'd5, 1'b0, 32'd130, 24'd400);
    queue_cmd(CMD_TICK, 8'd5, 1'b0, 32'd150, 24'd0);
    queue_cmd(CMD_RISK, 8'd5, 1'b1, 32'd1, 24'd2000);
    queue_cmd(CMD_FILL, 8'd5, 1'b1, 32'd160, 24'd1000);
    queue_cmd(CMD_FILL, 8'd6, 1'b1, 32'd50, 24'd300);
    queue_cmd(CMD_FILL, 8'd6, 1'b0, 32'd40, 24'd300);
    queue_cmd(CMD_FILL, 8'd7, 1'b0, 32'd0, 24'd0);
    queue_cmd(CMD_FILL, 8'd8, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_cmd(CMD_FILL, 8'd8, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_cmd(CMD_FILL, 8'd8, 1'b1, 32'd0, 24'hFF_FFFF);
    queue_cmd(CMD_TICK, 8'd8, 1'b1, 32'd0, 24'hFF_FFFF);
    queue_cmd(CMD_FILL, 8'd9, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_cmd(CMD_FILL, 8'd9, 1'b0, 32'd1, 24'd100);
    queue_cmd(CMD_TICK, 8'd9, 1'b0, 32'hFFFF_FFFF, 24'd0);
    queue_cmd(CMD_SPARE, 8'd255, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_cmd(CMD_RISK, 8'd255, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    queue_cmd(CMD_RISK, 8'd9, 1'b0, 32'hFFFF_FFFF, 24'hFF_FFFF);
    drain();

    set_limits('0, '0);
    queue_random(170);
    drain();
    set_limits('1, '1);
    queue_random(170);
    drain();
    set_limits(39'($urandom_range(0, 40000)), {24'd0, 32'($urandom)});
    queue_random(170);
    drain();
    set_limits(39'({$urandom, $urandom}), 56'({$urandom, $urandom}));
    queue_random(170);
    drain();
    set_limits(39'd1 << 24, 56'd1 << 40);
    queue_random(170);
    drain();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pkrt_pkg.sv
rtl/pkrt_mem.sv
rtl/pkrt_mul.sv
rtl/pkrt_div.sv
rtl/position_keeping_risk_table_top.sv
tb/sv/tb.sv
